// ----- design/bea_pkg.sv -----
// Shared types and constants for the button edge and auto-repeat block.
// Used by the lane, the output register and the top level; no dependencies.
package bea_pkg;

  localparam int InWidth = 8;
  localparam int RegWidth = 8;
  localparam int IndexWidth = 8;
  localparam int DefaultNumButtons = 8;

  localparam logic [RegWidth-1:0] ResetDelay = 8'd20;
  localparam logic [RegWidth-1:0] ResetRate = 8'd5;

  localparam logic [IndexWidth-1:0] RegRepeatDelay = 8'd0;
  localparam logic [IndexWidth-1:0] RegRepeatRate = 8'd1;

  typedef struct packed {
    logic [InWidth-1:0] held_mask;
    logic [InWidth-1:0] held_before;
    logic [InWidth-1:0] pressed_mask;
    logic [InWidth-1:0] released_mask;
    logic [InWidth-1:0] repeat_mask;
  } result_t;

endpackage

// ----- design/button_edge_autorepeat_top.sv -----
// Button edge detector with typematic auto-repeat, one counter lane per button.
// The result item is registered and appears in the cycle after its item is accepted.
// Throughput is one item per cycle unless the result is stalled; all lanes update together on each accepted item.
// The output register lets a new item in while the result is taken.
// Synchronous reset clears the held history, loads every counter with 20,
// and sets the delay and rate registers to 20 and 5.
module button_edge_autorepeat_top #(
  parameter int NUM_BUTTONS = bea_pkg::DefaultNumButtons
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [bea_pkg::InWidth-1:0]    held_now,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [bea_pkg::InWidth-1:0]    held_mask,
  output logic [bea_pkg::InWidth-1:0]    held_before,
  output logic [bea_pkg::InWidth-1:0]    pressed_mask,
  output logic [bea_pkg::InWidth-1:0]    released_mask,
  output logic [bea_pkg::InWidth-1:0]    repeat_mask,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bea_pkg::IndexWidth-1:0] cfg_index,
  input  logic [bea_pkg::RegWidth-1:0]   cfg_data
);

  localparam int W = (NUM_BUTTONS > bea_pkg::InWidth) ? NUM_BUTTONS : bea_pkg::InWidth;

  logic [bea_pkg::RegWidth-1:0] repeat_delay;
  logic [bea_pkg::RegWidth-1:0] repeat_rate;
  logic [W-1:0] last_held;
  logic [W-1:0] held_w;
  logic [W-1:0] pressed_w;
  logic [W-1:0] released_w;
  logic [W-1:0] repeat_w;
  logic [W-1:0] hit_w;
  logic         advance;
  bea_pkg::result_t res_next;
  bea_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign advance = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= bea_pkg::ResetDelay;
      repeat_rate <= bea_pkg::ResetRate;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bea_pkg::RegRepeatDelay) begin
        repeat_delay <= cfg_data;
      end else if (cfg_index == bea_pkg::RegRepeatRate) begin
        repeat_rate <= cfg_data;
      end
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_bit
    if (i < bea_pkg::InWidth && i < NUM_BUTTONS) begin : g_in
      assign held_w[i] = held_now[i];
    end else begin : g_zero
      assign held_w[i] = 1'b0;
    end
    if (i < NUM_BUTTONS) begin : g_lane
      bea_lane u_lane (
        .clk          (clk),
        .rst          (rst),
        .en           (advance),
        .held         (held_w[i]),
        .pressed      (pressed_w[i]),
        .repeat_delay (repeat_delay),
        .repeat_rate  (repeat_rate),
        .repeat_hit   (hit_w[i])
      );
    end else begin : g_nolane
      assign hit_w[i] = 1'b0;
    end
  end

  assign pressed_w = held_w & ~last_held;
  assign released_w = last_held & ~held_w;
  assign repeat_w = pressed_w | hit_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_held <= '0;
    end else if (advance) begin
      last_held <= held_w;
    end
  end

  always_comb begin
    res_next.held_mask = held_w[bea_pkg::InWidth-1:0];
    res_next.held_before = last_held[bea_pkg::InWidth-1:0];
    res_next.pressed_mask = pressed_w[bea_pkg::InWidth-1:0];
    res_next.released_mask = released_w[bea_pkg::InWidth-1:0];
    res_next.repeat_mask = repeat_w[bea_pkg::InWidth-1:0];
  end

  bea_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res_next (res_next),
    .stall    (result_stall),
    .valid    (result_valid),
    .res      (res)
  );

  assign held_mask = res.held_mask;
  assign held_before = res.held_before;
  assign pressed_mask = res.pressed_mask;
  assign released_mask = res.released_mask;
  assign repeat_mask = res.repeat_mask;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("Input stalled with no result waiting.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> result_valid)
    else $error("Accepted item produced no result.");

  a_repeat_only_held: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((repeat_mask & ~held_mask) == '0))
    else $error("Repeat pulse on a button that is not held.");

  a_press_is_repeat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((pressed_mask & ~repeat_mask) == '0))
    else $error("Fresh press missing from the repeat mask.");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((pressed_mask & released_mask) == '0))
    else $error("Button both pressed and released in one item.");

endmodule

// ----- design/bea_lane.sv -----
// One button lane: the repeat down-counter and its expiry pulse.
// Depends on bea_pkg for the register width and reset values.
module bea_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         held,
  input  logic                         pressed,
  input  logic [bea_pkg::RegWidth-1:0] repeat_delay,
  input  logic [bea_pkg::RegWidth-1:0] repeat_rate,
  output logic                         repeat_hit
);

  logic [bea_pkg::RegWidth-1:0] count;
  logic [bea_pkg::RegWidth-1:0] count_next;

  always_comb begin
    repeat_hit = held && !pressed && (count == '0);
    if (!held || pressed) begin
      count_next = repeat_delay;
    end else if (count != '0) begin
      count_next = count - bea_pkg::RegWidth'(1);
    end else begin
      count_next = repeat_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= bea_pkg::ResetDelay;
    end else if (en) begin
      count <= count_next;
    end
  end

endmodule

// ----- design/bea_out_reg.sv -----
// Output stage that holds the combined lane results as one registered result item.
// Depends on bea_pkg for the result structure.
module bea_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bea_pkg::result_t res_next,
  input  logic             stall,
  output logic             valid,
  output bea_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

// ----- dv/typematic_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the button edge and auto-repeat block: watches the item, result and
// register channels, predicts each result item from its own copy of the counters and
// compares field by field. Depends on bea_pkg for the result type and register indexes.
module typematic_checker #(
  parameter int NUM_BUTTONS = bea_pkg::DefaultNumButtons
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  logic [bea_pkg::InWidth-1:0]    held_now,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic [bea_pkg::InWidth-1:0]    held_mask,
  input  logic [bea_pkg::InWidth-1:0]    held_before,
  input  logic [bea_pkg::InWidth-1:0]    pressed_mask,
  input  logic [bea_pkg::InWidth-1:0]    released_mask,
  input  logic [bea_pkg::InWidth-1:0]    repeat_mask,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bea_pkg::IndexWidth-1:0] cfg_index,
  input  logic [bea_pkg::RegWidth-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked,
  output int                             repeats_seen
);

  localparam logic [bea_pkg::InWidth-1:0] ButtonField =
      (NUM_BUTTONS >= bea_pkg::InWidth) ? {bea_pkg::InWidth{1'b1}}
                                        : bea_pkg::InWidth'((1 << NUM_BUTTONS) - 1);

  logic [bea_pkg::RegWidth-1:0] delay_reg;
  logic [bea_pkg::RegWidth-1:0] rate_reg;
  logic [bea_pkg::InWidth-1:0]  prev_held;
  logic [bea_pkg::RegWidth-1:0] countdown [NUM_BUTTONS];
  bea_pkg::result_t             expected_ticks [$];

  initial begin
    fail_count = 0;
    pending = 0;
    results_checked = 0;
    repeats_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [bea_pkg::InWidth-1:0] got,
                             input logic [bea_pkg::InWidth-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
    end
  endtask

  function automatic bea_pkg::result_t typematic_step(
      input logic [bea_pkg::InWidth-1:0] sample);
    bea_pkg::result_t r;
    logic [bea_pkg::InWidth-1:0] held;
    logic [bea_pkg::InWidth-1:0] pressed;
    int i;
    held = sample & ButtonField;
    pressed = held & ~prev_held;
    r.held_mask = held;
    r.held_before = prev_held;
    r.pressed_mask = pressed;
    r.released_mask = prev_held & ~held;
    r.repeat_mask = pressed;
    for (i = 0; i < NUM_BUTTONS; i++) begin
      if (i < bea_pkg::InWidth && held[i % bea_pkg::InWidth]) begin
        if (pressed[i % bea_pkg::InWidth]) begin
          countdown[i] = delay_reg;
        end else if (countdown[i] != 0) begin
          countdown[i] = countdown[i] - 1'b1;
        end else begin
          r.repeat_mask[i % bea_pkg::InWidth] = 1'b1;
          countdown[i] = rate_reg;
        end
      end else begin
        countdown[i] = delay_reg;
      end
    end
    prev_held = held;
    return r;
  endfunction

  always @(posedge clk) begin
    bea_pkg::result_t got;
    bea_pkg::result_t want;
    if (rst) begin
      delay_reg = bea_pkg::ResetDelay;
      rate_reg = bea_pkg::ResetRate;
      prev_held = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) countdown[i] = bea_pkg::ResetDelay;
      expected_ticks.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = '{held_mask, held_before, pressed_mask, released_mask, repeat_mask};
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("result item %p with nothing expected", got));
        end else begin
          want = expected_ticks.pop_front();
          check_field("held_mask", got.held_mask, want.held_mask);
          check_field("held_before", got.held_before, want.held_before);
          check_field("pressed_mask", got.pressed_mask, want.pressed_mask);
          check_field("released_mask", got.released_mask, want.released_mask);
          check_field("repeat_mask", got.repeat_mask, want.repeat_mask);
          results_checked++;
          repeats_seen += $countones(want.repeat_mask & ~want.pressed_mask);
        end
      end
      if (item_valid && !item_stall) begin
        expected_ticks.push_back(typematic_step(held_now));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bea_pkg::RegRepeatDelay: delay_reg = cfg_data;
          bea_pkg::RegRepeatRate:  rate_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_ticks.size();
  end

endmodule

// ----- dv/button_edge_autorepeat_top_tb.sv -----
`timescale 1ns / 1ps
// Top of the testbench for button_edge_autorepeat_top: clock, reset, tick and register
// stimulus with random gaps and result stalls, and the final verdict.
// Depends on bea_pkg, the block itself and typematic_checker.
module button_edge_autorepeat_top_tb;

  localparam int NumButtons = bea_pkg::DefaultNumButtons;
  localparam int TicksPerPhase = 192;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic [bea_pkg::InWidth-1:0]    held_now = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [bea_pkg::InWidth-1:0]    held_mask;
  logic [bea_pkg::InWidth-1:0]    held_before;
  logic [bea_pkg::InWidth-1:0]    pressed_mask;
  logic [bea_pkg::InWidth-1:0]    released_mask;
  logic [bea_pkg::InWidth-1:0]    repeat_mask;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bea_pkg::IndexWidth-1:0] cfg_index = '0;
  logic [bea_pkg::RegWidth-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int repeats_seen;
  int ticks_sent = 0;
  int reg_writes = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  always #6 clk = ~clk;

  button_edge_autorepeat_top #(.NUM_BUTTONS(NumButtons)) dut (.*);

  typematic_checker #(.NUM_BUTTONS(NumButtons)) u_checker (.*);

  always @(posedge clk) begin
    int n;
    n = stall_left;
    if (result_valid && !result_stall) n = no_idle ? 0 : $urandom_range(0, 13);
    if (n > 0) begin
      result_stall <= 1'b1;
      stall_left <= n - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  task automatic send_tick(input logic [bea_pkg::InWidth-1:0] mask);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    held_now <= mask;
    do @(posedge clk); while (item_stall);
    ticks_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [bea_pkg::IndexWidth-1:0] idx,
                         input logic [bea_pkg::RegWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [bea_pkg::RegWidth-1:0] delay;
    logic [bea_pkg::RegWidth-1:0] rate;
    logic [bea_pkg::InWidth-1:0]  mask;
    logic [bea_pkg::InWidth-1:0]  tick;
    int                           phase;
    int                           sent;
    int                           run_len;
    int                           run_cap;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values, edges on the extreme masks.
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h80);
    send_tick(8'h01);
    send_tick(8'h0F);
    send_tick(8'hF0);
    settle();

    // Zero delay and rate: a held button pulses on every following tick.
    set_reg(bea_pkg::RegRepeatDelay, 8'h00);
    set_reg(bea_pkg::RegRepeatRate, 8'h00);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'h03);
    send_tick(8'h03);
    send_tick(8'h00);
    settle();

    // Short delay and rate, then a change while the counters are running.
    set_reg(bea_pkg::RegRepeatDelay, 8'h02);
    set_reg(bea_pkg::RegRepeatRate, 8'h01);
    repeat (7) send_tick(8'hFF);
    settle();
    set_reg(bea_pkg::RegRepeatDelay, 8'hFF);
    set_reg(bea_pkg::RegRepeatRate, 8'hFF);
    repeat (3) send_tick(8'hFF);
    settle();

    // Writes to indexes that name no register must leave both registers alone.
    set_reg(8'h02, 8'h00);
    set_reg(8'hFF, 8'h00);
    send_tick(8'h00);
    send_tick(8'h55);
    settle();

    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin delay = 8'h00; rate = 8'h00; end
        1: begin delay = 8'hFF; rate = 8'hFF; end
        2: begin delay = 8'hFF; rate = 8'h00; end
        3: begin delay = 8'h00; rate = 8'hFF; end
        4, 5: begin
          delay = bea_pkg::RegWidth'($urandom_range(0, 255));
          rate = bea_pkg::RegWidth'($urandom_range(0, 255));
        end
        default: begin
          delay = bea_pkg::RegWidth'($urandom_range(0, 6));
          rate = bea_pkg::RegWidth'($urandom_range(0, 4));
        end
      endcase
      no_idle = (phase % 3 == 2);
      set_reg(bea_pkg::RegRepeatDelay, delay);
      set_reg(bea_pkg::RegRepeatRate, rate);
      if ($urandom_range(0, 1)) begin
        set_reg(bea_pkg::IndexWidth'($urandom_range(2, 255)),
                bea_pkg::RegWidth'($urandom_range(0, 255)));
      end
      run_cap = int'(delay) + 3 * int'(rate) + 4;
      if (run_cap > 300) run_cap = 300;
      sent = 0;
      while (sent < TicksPerPhase) begin
        mask = bea_pkg::InWidth'($urandom_range(0, 255));
        run_len = $urandom_range(1, run_cap);
        if (run_len > TicksPerPhase - sent) run_len = TicksPerPhase - sent;
        repeat (run_len) begin
          tick = mask;
          if ($urandom_range(0, 9) == 0) begin
            tick = tick ^ bea_pkg::InWidth'(1 << $urandom_range(0, 7));
          end
          send_tick(tick);
          sent++;
        end
      end
      settle();
    end

    no_idle = 1'b0;
    settle();
    repeat (8) @(posedge clk);

    $display("Summary: %0d ticks sent over %0d register writes, %0d results compared.",
             ticks_sent, reg_writes, results_checked);
    $display("Summary: %0d auto-repeat pulses beyond fresh presses were predicted.",
             repeats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
